### sv/spd_pkg.sv
// ----------------------------------------------------------------------------
// spd_pkg
// Shared widths, reset constants and types of the strobe peak detector.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    // request field widths
    localparam int CH_W      = 6;
    localparam int SAMPLE_W  = 16;
    localparam int POS_W     = 12;

    // threshold and decay step are never negative and never above a sample
    localparam int THR_W     = SAMPLE_W - 1;

    // configuration port
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

    localparam logic [CFG_W-1:0] DECAY_RESET   = 16'd882;
    localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd132;

    // window contents at the start of a frame
    localparam logic signed [SAMPLE_W-1:0] OLDER_RESET  = 16'sd10000;
    localparam logic signed [SAMPLE_W-1:0] MIDDLE_RESET = 16'sd5000;

    // per channel state word
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] older;
        logic signed [SAMPLE_W-1:0] middle;
        logic signed [SAMPLE_W-1:0] newest;
        logic [THR_W-1:0]           thr;
        logic [THR_W-1:0]           step;
        logic                       strobed;
        logic [POS_W-1:0]           last_pos;
    } chan_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear;
        logic accept;
        logic eval;
        logic start_div;
        logic write;
        logic load_out;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic need_div;
        logic div_done;
        logic out_free;
    } status_t;

    // state of a channel after reset
    function automatic chan_state_t reset_state();
        chan_state_t s;
        s.older    = OLDER_RESET;
        s.middle   = MIDDLE_RESET;
        s.newest   = '0;
        s.thr      = '0;
        s.step     = THR_W'(1);
        s.strobed  = 1'b0;
        s.last_pos = '0;
        return s;
    endfunction

endpackage

`default_nettype wire

### sv/spd_if.sv
// ----------------------------------------------------------------------------
// spd_if
// Valid/ready channels for sample requests and strobe results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spd_in_if;
    logic                                valid;
    logic                                ready;
    logic [spd_pkg::CH_W-1:0]            channel;
    logic signed [spd_pkg::SAMPLE_W-1:0] sample;
    logic [spd_pkg::POS_W-1:0]           position;

    modport source (output valid, output channel, output sample, output position,
                    input ready);
    modport sink   (input valid, input channel, input sample, input position,
                    output ready);
endinterface

interface spd_out_if;
    logic                     valid;
    logic                     ready;
    logic [spd_pkg::CH_W-1:0] out_channel;
    logic                     strobe_res;

    modport source (output valid, output out_channel, output strobe_res, input ready);
    modport sink   (input valid, input out_channel, input strobe_res, output ready);
endinterface

`default_nettype wire

### sv/spd_divider.sv
// ----------------------------------------------------------------------------
// spd_divider
// Restoring divider, one quotient bit per cycle, giving the rounded-up quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [spd_pkg::THR_W-1:0]     dividend,
    input  wire logic [spd_pkg::CFG_W-1:0]     divisor,
    output logic                               done,
    output logic [spd_pkg::THR_W-1:0]          quotient_ceil
);

    localparam int QW    = spd_pkg::THR_W;
    localparam int RW    = spd_pkg::CFG_W;
    localparam int CNT_W = $clog2(QW + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [QW-1:0]    q_reg;
    logic [RW-1:0]    rem_reg;
    logic [RW-1:0]    den_reg;
    logic [RW:0]      trial;
    logic [RW:0]      diff;
    logic             fits;

    // one trial subtraction
    always_comb
    begin
        trial = {rem_reg, q_reg[QW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = trial >= {1'b0, den_reg};
    end

    // iteration counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (start)
        begin
            cnt_next = CNT_W'(QW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    // quotient and remainder shift
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? diff[RW-1:0] : trial[RW-1:0];
            q_reg   <= {q_reg[QW-2:0], fits};
        end
    end

    assign done          = (cnt_reg == '0);
    // round up on a nonzero remainder; cannot overflow since divisor 1 leaves none
    assign quotient_ceil = QW'({1'b0, q_reg} + (QW + 1)'(rem_reg != '0));

endmodule

`default_nettype wire

### sv/spd_datapath.sv
// ----------------------------------------------------------------------------
// spd_datapath
// Channel state memory, window update, strobe decision, threshold decay,
// configuration registers and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_datapath #(
    parameter int CHANNELS = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire spd_pkg::cmd_t                       cmd,
    output spd_pkg::status_t                         status,
    input  wire logic [spd_pkg::CH_W-1:0]            in_channel,
    input  wire logic signed [spd_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic [spd_pkg::POS_W-1:0]           in_position,
    input  wire logic                                cfg_wen,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]       cfg_addr,
    input  wire logic [spd_pkg::CFG_W-1:0]           cfg_wdata,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [spd_pkg::CH_W-1:0]                 out_channel,
    output logic                                     strobe_res
);

    localparam int AW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SW   = spd_pkg::SAMPLE_W;
    localparam int TW   = spd_pkg::THR_W;
    localparam int PW   = spd_pkg::POS_W;
    localparam int CW   = spd_pkg::CFG_W;
    localparam int CHW  = spd_pkg::CH_W;
    localparam int LATE_W = CW + 2;

    spd_pkg::chan_state_t mem [CHANNELS];

    logic [CW-1:0]            decay_reg, decay_next;
    logic [CW-1:0]            timeout_reg, timeout_next;
    logic [AW-1:0]            clr_addr_reg, clr_addr_next;
    logic                     out_valid_reg, out_valid_next;

    logic [CHW-1:0]           ch_reg;
    logic [AW-1:0]            addr_reg;
    logic                     ch_ok_reg;
    logic signed [SW-1:0]     sample_reg;
    logic [PW-1:0]            pos_reg;
    spd_pkg::chan_state_t     rdata_reg;

    spd_pkg::chan_state_t     win_reg;
    logic                     ge_reg;
    logic                     strobe_reg;

    logic [CHW-1:0]           out_channel_reg;
    logic                     strobe_res_reg;

    spd_pkg::chan_state_t     base;
    spd_pkg::chan_state_t     nxt;
    logic                     ge;
    logic                     peak;
    logic                     late;
    logic                     strobe;
    logic                     in_ok;

    logic                     div_done;
    logic [TW-1:0]            div_ceil;
    logic [TW-1:0]            step_w;
    spd_pkg::chan_state_t     wword;

    // configuration registers
    always_comb
    begin
        decay_next   = decay_reg;
        timeout_next = timeout_reg;
        if (cfg_wen)
        begin
            unique case (cfg_addr)
                spd_pkg::CFG_DECAY:   decay_next   = cfg_wdata;
                spd_pkg::CFG_TIMEOUT: timeout_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    // clear sweep address and result valid
    always_comb
    begin
        clr_addr_next = cmd.clear ? clr_addr_reg + AW'(1) : clr_addr_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg     <= spd_pkg::DECAY_RESET;
            timeout_reg   <= spd_pkg::TIMEOUT_RESET;
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            decay_reg     <= decay_next;
            timeout_reg   <= timeout_next;
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // capture the request and read its channel state
    assign in_ok = ({{(32 - CHW){1'b0}}, in_channel} < 32'(CHANNELS));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ch_reg     <= in_channel;
            addr_reg   <= AW'(in_channel);
            ch_ok_reg  <= in_ok;
            sample_reg <= in_sample;
            pos_reg    <= in_position;
            rdata_reg  <= mem[AW'(in_channel)];
        end
    end

    // window shift, threshold compare, peak and timeout tests
    always_comb
    begin
        base = rdata_reg;
        if (pos_reg == '0)
        begin
            base.older    = spd_pkg::OLDER_RESET;
            base.middle   = spd_pkg::MIDDLE_RESET;
            base.newest   = '0;
            base.strobed  = 1'b0;
            base.last_pos = '0;
        end
        nxt        = base;
        nxt.older  = base.middle;
        nxt.middle = base.newest;
        nxt.newest = sample_reg;

        ge   = ch_ok_reg && (nxt.middle >= $signed({1'b0, base.thr}));
        peak = (nxt.older < nxt.middle) && (nxt.newest < nxt.middle);
        // position - 1 - last > timeout, kept unsigned
        late = {{(LATE_W - PW){1'b0}}, pos_reg} >
               ({{(LATE_W - PW){1'b0}}, base.last_pos} +
                {{(LATE_W - CW){1'b0}}, timeout_reg} + LATE_W'(1));
        strobe = ge && peak && (!base.strobed || late);

        if (ge)
        begin
            nxt.thr = nxt.middle[TW-1:0];
        end
        if (strobe)
        begin
            nxt.strobed  = 1'b1;
            nxt.last_pos = pos_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval)
        begin
            win_reg    <= nxt;
            ge_reg     <= ge;
            strobe_reg <= strobe;
        end
    end

    // decay step = ceil(threshold / decay length)
    spd_divider u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (cmd.start_div),
        .dividend      (nxt.middle[TW-1:0]),
        .divisor       (decay_reg),
        .done          (div_done),
        .quotient_ceil (div_ceil)
    );

    // new step and decayed threshold
    always_comb
    begin
        if (!ge_reg)
        begin
            step_w = win_reg.step;
        end
        else if (decay_reg == '0)
        begin
            step_w = win_reg.thr;
        end
        else
        begin
            step_w = div_ceil;
        end
        wword      = win_reg;
        wword.step = step_w;
        wword.thr  = (win_reg.thr > step_w) ? win_reg.thr - step_w : '0;
    end

    // state memory write port
    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            mem[clr_addr_reg] <= spd_pkg::reset_state();
        end
        else if (cmd.write && ch_ok_reg)
        begin
            mem[addr_reg] <= wword;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_channel_reg <= ch_reg;
            strobe_res_reg  <= strobe_reg;
        end
    end

    always_comb
    begin
        status.clear_last = (clr_addr_reg == AW'(CHANNELS - 1));
        status.need_div   = ge;
        status.div_done   = div_done;
        status.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid   = out_valid_reg;
    assign out_channel = out_channel_reg;
    assign strobe_res  = strobe_res_reg;

endmodule

`default_nettype wire

### sv/spd_ctrl.sv
// ----------------------------------------------------------------------------
// spd_ctrl
// Sequencer: clear sweep, request accept, evaluate, divide, write back.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire spd_pkg::status_t  status,
    output spd_pkg::cmd_t          cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_READ  = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_WRITE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.eval = 1'b1;
                if (status.need_div)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIV;
                end
                else
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                // rewriting the same word while the result waits is harmless
                cmd.write = 1'b1;
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

### sv/strobe_peak_detector.sv
// ----------------------------------------------------------------------------
// strobe_peak_detector
// Multi-channel local-maximum strobe detector with a decaying threshold.
//
// in_ch carries one request per sample: channel, sample, position in frame.
// out_ch returns one result per request: the channel and a strobe flag for
// the previous sample of that channel. Both are valid/ready channels.
// cfg_wen/cfg_addr/cfg_wdata write the decay length (index 0) and the
// strobe timeout (index 1); write them only while no request is in flight.
// A request goes from accept through evaluation to write-back and the
// result register. When the previous sample reaches the threshold, the
// decay step first comes from a serial divider giving one quotient bit
// per cycle. The state memory has one read and one write port, so
// requests are handled one at a time and a new one is taken only after
// the last is written back, though the next one is taken while a result
// still waits. After reset a clearing sweep writes every channel's state
// with in_ch not ready. If out_ch stalls, the finished request
// holds in its write-back step and no new request is taken until the
// waiting result leaves the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module strobe_peak_detector #(
    parameter int CHANNELS = 64
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    spd_in_if.sink                                 in_ch,
    spd_out_if.source                              out_ch,
    input  wire logic                              cfg_wen,
    input  wire logic [spd_pkg::CFG_IDX_W-1:0]     cfg_addr,
    input  wire logic [spd_pkg::CFG_W-1:0]         cfg_wdata
);

    spd_pkg::cmd_t    cmd;
    spd_pkg::status_t status;
    logic             in_ready;
    logic             out_valid;
    logic [spd_pkg::CH_W-1:0] out_channel;
    logic             strobe_res;

    // sequencer
    spd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // state memory and arithmetic
    spd_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .in_channel  (in_ch.channel),
        .in_sample   (in_ch.sample),
        .in_position (in_ch.position),
        .cfg_wen     (cfg_wen),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .out_valid   (out_valid),
        .out_ready   (out_ch.ready),
        .out_channel (out_channel),
        .strobe_res  (strobe_res)
    );

    assign in_ch.ready        = in_ready;
    assign out_ch.valid       = out_valid;
    assign out_ch.out_channel = out_channel;
    assign out_ch.strobe_res  = strobe_res;

endmodule

`default_nettype wire
